### hw/rtl/assert_macros.svh
// Assertion macros used by the parser module (expects clk and rst_n in scope).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rufp_pkg.sv
// Shared types and constants for the sensor UART frame parser.
`default_nettype none

package rufp_pkg;

    localparam int unsigned HEAD_LEN_DEF = 4;
    localparam int unsigned MAX_BODY     = 32;
    localparam int unsigned SHADOW_N     = 12;
    localparam int unsigned OFF_W        = 6;

    // Last byte of each head / tail run; earlier bytes count up by one each.
    localparam logic [7:0] ACK_HEAD_LAST = 8'hFA;
    localparam logic [7:0] REP_HEAD_LAST = 8'hF1;
    localparam logic [7:0] ACK_TAIL_LAST = 8'h01;
    localparam logic [7:0] REP_TAIL_LAST = 8'hF5;

    localparam logic [15:0] CMD_ENTER_CFG = 16'h01FF;
    localparam logic [15:0] CMD_EXIT_CFG  = 16'h01FE;
    localparam logic [15:0] CMD_RANGE_TGL = 16'h01AA;
    localparam logic [15:0] CMD_NOISE_GO  = 16'h010B;
    localparam logic [15:0] CMD_NOISE_QRY = 16'h011B;

    localparam logic [7:0] REPORT_TYPE = 8'h02;
    localparam logic [7:0] TARGET_MAX  = 8'h06;
    localparam logic [7:0] NOISE_MAX   = 8'h02;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN0 = 3'd1,
        PH_LEN1 = 3'd2,
        PH_BODY = 3'd3,
        PH_TAIL = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_LEN    = 3'd1,
        ST_UNKNOWN_CMD = 3'd2,
        ST_BAD_TYPE    = 3'd3,
        ST_BAD_TARGET  = 3'd4,
        ST_BAD_NOISE   = 3'd5,
        ST_BAD_TAIL    = 3'd6,
        ST_OVERSIZE    = 3'd7
    } status_t;

    typedef enum logic {
        KIND_ACK    = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

endpackage

`default_nettype wire

### hw/rtl/radar_uart_frame_parser_unit.sv
// Sensor UART frame parser: head hunt, length, body capture, tail check, decode.
`default_nettype none

// Usage
// - Input channel (byte_valid / byte_stall / rx_byte): one received serial
//   byte per word. A word is taken on a rising edge with byte_valid high and
//   byte_stall low.
// - Output channel (frame_valid / frame_stall / payload): one word per frame
//   end (good frame, zero length, oversize length, or any decode error).
//   Sensor and target fields show the held registers after this frame.
// - Path: a byte lands in an input register on acceptance; from there the
//   parser takes it once the result register is free and, on a frame end,
//   loads the result register.
// - Throughput: one byte per cycle while the output side drains; the only
//   limit is the single result register.
// - Stall: while a result waits under frame_stall, the byte in the input
//   register stays put and byte_stall is high as long as that register holds
//   a byte. Held sensor/target registers only change when a new result is
//   loaded, so a stalled result does not change.
// - Reset: hunting for a head, no result pending, range resolution coarse,
//   every other held field zero.
module radar_uart_frame_parser_unit #(
    parameter int unsigned HEAD_LEN = rufp_pkg::HEAD_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output      logic        byte_stall,
    input  wire logic [7:0]  rx_byte,
    output      logic        frame_valid,
    input  wire logic        frame_stall,
    output      logic [2:0]  frame_status,
    output      logic        frame_kind,
    output      logic [2:0]  target_code,
    output      logic [15:0] move_distance,
    output      logic [7:0]  move_energy,
    output      logic [15:0] still_distance,
    output      logic [7:0]  still_energy,
    output      logic [15:0] detect_distance,
    output      logic        config_active,
    output      logic [15:0] proto_version,
    output      logic        coarse_range,
    output      logic [1:0]  noise_cal_state
);
    import rufp_pkg::*;

    `include "assert_macros.svh"

    // head / tail match counter holds up to HEAD_LEN
    localparam int unsigned HM_W = $clog2(HEAD_LEN + 1);

    // handshake and stage registers
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             res_valid_reg;
    status_t          res_status_reg;
    kind_t            res_kind_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [HM_W-1:0]  hm_reg, hm_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [OFF_W-1:0] body_len_reg, body_len_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [7:0]       shadow_reg [SHADOW_N];
    logic [7:0]       shadow_next [SHADOW_N];

    // held sensor and target fields
    logic             cfg_reg, cfg_next;
    logic [15:0]      version_reg, version_next;
    logic             range_reg, range_next;
    logic [1:0]       noise_reg, noise_next;
    logic [2:0]       tgt_code_reg, tgt_code_next;
    logic [15:0]      move_dist_reg, move_dist_next;
    logic [7:0]       move_energy_reg, move_energy_next;
    logic [15:0]      still_dist_reg, still_dist_next;
    logic [7:0]       still_energy_reg, still_energy_next;
    logic [15:0]      detect_dist_reg, detect_dist_next;

    logic             out_free;
    logic             s1_fire;
    logic             byte_take;
    logic             emit;
    status_t          status;
    logic             head_done;
    logic             body_done;
    logic             tail_done;

    logic [7:0]       b;
    logic [7:0]       head_last;
    logic [7:0]       tail_last;
    logic [7:0]       head_exp;
    logic [7:0]       tail_exp;
    logic [HM_W-1:0]  hm_hunt;
    logic [HM_W-1:0]  hm_tail;
    logic [15:0]      len_full;
    logic [OFF_W-1:0] offset_inc;
    logic [15:0]      cmd_word;

    // ---------------- handshake ----------------
    // The parser stage advances whenever it holds a byte and the result register can take a word.
    assign out_free   = !res_valid_reg || !frame_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;
    assign byte_take  = byte_valid && !byte_stall;

    assign b = s1_byte_reg;

    // ---------------- head / tail expected bytes ----------------
    assign head_last = (kind_reg == KIND_REPORT) ? REP_HEAD_LAST : ACK_HEAD_LAST;
    assign tail_last = (kind_reg == KIND_REPORT) ? REP_TAIL_LAST : ACK_TAIL_LAST;
    // next head byte after hm_reg matched ones (the first head byte is skipped)
    assign head_exp  = head_last + 8'(HEAD_LEN - 2) - 8'(hm_reg);
    assign tail_exp  = tail_last + 8'(HEAD_LEN - 1) - 8'(offset_reg);

    assign len_full   = {b, len_lo_reg};
    assign offset_inc = offset_reg + 1'b1;
    assign cmd_word   = {shadow_reg[1], shadow_reg[0]};

    always_comb
    begin
        if (hm_reg != '0 && hm_reg < HM_W'(HEAD_LEN - 1) && b == head_exp)
            hm_hunt = hm_reg + 1'b1;
        else if (b == ACK_HEAD_LAST + 8'(HEAD_LEN - 2) ||
                 b == REP_HEAD_LAST + 8'(HEAD_LEN - 2))
            hm_hunt = HM_W'(1);
        else
            hm_hunt = '0;
    end

    assign hm_tail = (b == tail_exp) ? hm_reg + 1'b1 : hm_reg;

    // ---------------- datapath next values ----------------
    always_comb
    begin
        hm_next           = hm_reg;
        kind_next         = kind_reg;
        len_lo_next       = len_lo_reg;
        body_len_next     = body_len_reg;
        offset_next       = offset_reg;
        shadow_next       = shadow_reg;
        cfg_next          = cfg_reg;
        version_next      = version_reg;
        range_next        = range_reg;
        noise_next        = noise_reg;
        tgt_code_next     = tgt_code_reg;
        move_dist_next    = move_dist_reg;
        move_energy_next  = move_energy_reg;
        still_dist_next   = still_dist_reg;
        still_energy_next = still_energy_reg;
        detect_dist_next  = detect_dist_reg;
        emit              = 1'b0;
        status            = ST_OK;
        head_done         = 1'b0;
        body_done         = 1'b0;
        tail_done         = 1'b0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                // a fresh start picks the head kind; a continuation keeps it
                if (!(hm_reg != '0 && hm_reg < HM_W'(HEAD_LEN - 1) && b == head_exp))
                begin
                    if (b == ACK_HEAD_LAST + 8'(HEAD_LEN - 2))
                        kind_next = KIND_ACK;
                    else if (b == REP_HEAD_LAST + 8'(HEAD_LEN - 2))
                        kind_next = KIND_REPORT;
                end
                if (hm_hunt == HM_W'(HEAD_LEN - 1))
                begin
                    head_done = 1'b1;
                    hm_next   = '0;
                end
                else
                begin
                    hm_next = hm_hunt;
                end
            end
            PH_LEN0:
            begin
                len_lo_next = b;
            end
            PH_LEN1:
            begin
                if (len_full == 16'd0)
                begin
                    emit    = 1'b1;
                    status  = ST_ZERO_LEN;
                    hm_next = '0;
                end
                else if (len_full > 16'(MAX_BODY))
                begin
                    emit    = 1'b1;
                    status  = ST_OVERSIZE;
                    hm_next = '0;
                end
                else
                begin
                    body_len_next = len_full[OFF_W-1:0];
                    offset_next   = '0;
                    for (int i = 0; i < SHADOW_N; i++)
                    begin
                        shadow_next[i] = 8'h00;
                    end
                end
            end
            PH_BODY:
            begin
                for (int i = 0; i < SHADOW_N; i++)
                begin
                    if (offset_reg == OFF_W'(i))
                        shadow_next[i] = b;
                end
                if (offset_inc >= body_len_reg)
                begin
                    body_done   = 1'b1;
                    offset_next = '0;
                    hm_next     = '0;
                end
                else
                begin
                    offset_next = offset_inc;
                end
            end
            PH_TAIL:
            begin
                offset_next = offset_inc;
                hm_next     = hm_tail;
                if (offset_reg == OFF_W'(HEAD_LEN - 1))
                begin
                    tail_done = 1'b1;
                    emit      = 1'b1;
                    hm_next   = '0;
                    if (hm_tail != HM_W'(HEAD_LEN))
                    begin
                        status = ST_BAD_TAIL;
                    end
                    else if (kind_reg == KIND_ACK)
                    begin
                        unique case (cmd_word)
                            CMD_ENTER_CFG:
                            begin
                                cfg_next     = 1'b1;
                                version_next = {shadow_reg[3], shadow_reg[2]};
                            end
                            CMD_EXIT_CFG:  cfg_next   = 1'b0;
                            CMD_RANGE_TGL: range_next = !range_reg;
                            CMD_NOISE_GO:  noise_next = 2'd1;
                            CMD_NOISE_QRY:
                            begin
                                if (shadow_reg[2] > NOISE_MAX)
                                    status = ST_BAD_NOISE;
                                else
                                    noise_next = shadow_reg[2][1:0];
                            end
                            default:       status = ST_UNKNOWN_CMD;
                        endcase
                    end
                    else if (shadow_reg[0] != REPORT_TYPE)
                    begin
                        status = ST_BAD_TYPE;
                    end
                    else if (shadow_reg[2] > TARGET_MAX)
                    begin
                        status = ST_BAD_TARGET;
                    end
                    else
                    begin
                        tgt_code_next     = shadow_reg[2][2:0];
                        move_dist_next    = {shadow_reg[4], shadow_reg[3]};
                        move_energy_next  = shadow_reg[5];
                        still_dist_next   = {shadow_reg[7], shadow_reg[6]};
                        still_energy_next = shadow_reg[8];
                        detect_dist_next  = {shadow_reg[10], shadow_reg[9]};
                    end
                end
            end
            default:
            begin
                hm_next = '0;
            end
        endcase
    end

    // ---------------- phase sequencing ----------------
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT: if (head_done) phase_next = PH_LEN0;
            PH_LEN0: phase_next = PH_LEN1;
            PH_LEN1: phase_next = emit ? PH_HUNT : PH_BODY;
            PH_BODY: if (body_done) phase_next = PH_TAIL;
            PH_TAIL: if (tail_done) phase_next = PH_HUNT;
            default: phase_next = PH_HUNT;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            phase_reg        <= PH_HUNT;
            hm_reg           <= '0;
            kind_reg         <= KIND_ACK;
            len_lo_reg       <= 8'h00;
            body_len_reg     <= '0;
            offset_reg       <= '0;
            cfg_reg          <= 1'b0;
            version_reg      <= 16'h0000;
            range_reg        <= 1'b1;
            noise_reg        <= 2'd0;
            tgt_code_reg     <= 3'd0;
            move_dist_reg    <= 16'h0000;
            move_energy_reg  <= 8'h00;
            still_dist_reg   <= 16'h0000;
            still_energy_reg <= 8'h00;
            detect_dist_reg  <= 16'h0000;
        end
        else
        begin
            if (!byte_stall)
                s1_valid_reg <= byte_valid;
            if (out_free)
                res_valid_reg <= s1_fire && emit;
            if (s1_fire)
            begin
                phase_reg        <= phase_next;
                hm_reg           <= hm_next;
                kind_reg         <= kind_next;
                len_lo_reg       <= len_lo_next;
                body_len_reg     <= body_len_next;
                offset_reg       <= offset_next;
                cfg_reg          <= cfg_next;
                version_reg      <= version_next;
                range_reg        <= range_next;
                noise_reg        <= noise_next;
                tgt_code_reg     <= tgt_code_next;
                move_dist_reg    <= move_dist_next;
                move_energy_reg  <= move_energy_next;
                still_dist_reg   <= still_dist_next;
                still_energy_reg <= still_energy_next;
                detect_dist_reg  <= detect_dist_next;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (byte_take)
            s1_byte_reg <= rx_byte;
        if (s1_fire)
            shadow_reg <= shadow_next;
        if (s1_fire && emit)
        begin
            res_status_reg <= status;
            res_kind_reg   <= kind_reg;
        end
    end

    // ---------------- outputs ----------------
    // held fields only move when a new result loads, so they act as payload
    assign frame_valid     = res_valid_reg;
    assign frame_status    = res_status_reg;
    assign frame_kind      = res_kind_reg;
    assign target_code     = tgt_code_reg;
    assign move_distance   = move_dist_reg;
    assign move_energy     = move_energy_reg;
    assign still_distance  = still_dist_reg;
    assign still_energy    = still_energy_reg;
    assign detect_distance = detect_dist_reg;
    assign config_active   = cfg_reg;
    assign proto_version   = version_reg;
    assign coarse_range    = range_reg;
    assign noise_cal_state = noise_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMPLIES(a_stall_cause, byte_stall, s1_valid_reg && res_valid_reg && frame_stall,
        "input stalled without a blocked result")
    `ASSERT_IMPLIES(a_hm_range, 1'b1, hm_reg <= HM_W'(HEAD_LEN),
        "match counter beyond head length")
    `ASSERT_IMPLIES(a_body_offset, phase_reg == PH_BODY,
        offset_reg < body_len_reg && body_len_reg <= OFF_W'(MAX_BODY),
        "body offset out of range")
    `ASSERT_NEXT(a_cfg_hold, !(s1_fire && emit), $stable(cfg_reg) && $stable(tgt_code_reg),
        "held field changed without a result")
    `ASSERT_IMPLIES(a_target_code, 1'b1, tgt_code_reg <= 3'(TARGET_MAX),
        "target code out of range")

endmodule

`default_nettype wire
